/* rtl/ilst_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list store package
// Request codes, status codes and the per-cell control bundle shared by the
// core, its cells and the port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ilst_pkg;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_ERASE   = 3'd1,
    FN_REPLACE = 3'd2,
    FN_READ    = 3'd3,
    FN_RESIZE  = 3'd4,
    FN_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic era;
    logic rep;
    logic fil;
    logic rd;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/ilst_cell.sv */
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one word of the sequence and updates it each cycle from its own
// word, its left or right neighbor, or the request word.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_cell #(
  parameter int INDEX      = 0,
  parameter int CMP_W      = 7,
  parameter int DATA_WIDTH = 32
) (
  input  wire                     clk,
  input  ilst_pkg::cell_ctl_t     ctl,
  input  wire  [CMP_W-1:0]        pos,
  input  wire  [CMP_W-1:0]        len,
  input  wire  [CMP_W-1:0]        target,
  input  wire  [DATA_WIDTH-1:0]   word,
  input  wire  [DATA_WIDTH-1:0]   left_data,
  input  wire  [DATA_WIDTH-1:0]   right_data,
  output logic [DATA_WIDTH-1:0]   data,
  output logic [DATA_WIDTH-1:0]   read_tap
);
  import ilst_pkg::*;

  localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;

  assign hit = (IDX == pos);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (hit) begin
        data_nxt = word;
      end else if ((IDX > pos) && (IDX <= len)) begin
        data_nxt = left_data;
      end
    end else if (ctl.era) begin
      if ((IDX >= pos) && (IDX_NEXT < len)) begin
        data_nxt = right_data;
      end
    end else if (ctl.rep) begin
      if (hit) begin
        data_nxt = word;
      end
    end else if (ctl.fil) begin
      if ((IDX >= len) && (IDX < target)) begin
        data_nxt = word;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign read_tap = (ctl.rd && hit) ? data_r : '0;

endmodule

`default_nettype wire

/* rtl/indexed_list_store_core.sv */
// ----------------------------------------------------------------------------
// Indexed list store core
// An ordered sequence of up to CAPACITY words with insert, erase, replace,
// read, resize and clear requests, kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request item (in_func, in_position,
//   in_value, in_new_length) per accepted handshake. Each request gives
//   exactly one result item (out_status, out_read_value, out_length).
//   A request is checked against the current length or the capacity, and
//   every cell then compares its own index with the position and length
//   and shifts, writes, fills or keeps its word in the same cycle, so the
//   result appears in the cycle after acceptance. One item is taken per
//   cycle while no result waits under out_stall.
//   The result sits in an output register. While a result waits under
//   out_stall, in_stall is raised and no new request is taken; once the
//   result is taken, a new request may be accepted in that same cycle.
//   Reset empties the sequence and drops any pending result. Cell words
//   are not cleared; a word below the length has always been written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_func,
  input  wire  [6:0]  in_position,
  input  wire  [31:0] in_value,
  input  wire  [6:0]  in_new_length,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_length
);
  import ilst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]      len_r;
  logic [CNT_W-1:0]      len_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [31:0]           out_read_value_r;
  logic [6:0]            out_length_r;

  logic                  accept;
  status_t               status;
  cell_ctl_t             ctl;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      len_ext;
  logic [CMP_W-1:0]      target_ext;
  logic [CMP_W-1:0]      len_out;
  logic [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [EXT_W-1:0]      rd_ext;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_ext    = CMP_W'(in_position);
  assign target_ext = CMP_W'(in_new_length);
  assign len_ext    = CMP_W'(len_r);
  assign value_ext  = EXT_W'(signed'(in_value));
  assign word       = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    status  = ST_OK;
    ctl     = '0;
    len_nxt = len_r;
    unique case (func_t'(in_func))
      FN_INSERT: begin
        if (pos_ext > len_ext) begin
          status = ST_RANGE;
        end else if (len_ext >= CAP_C) begin
          status = ST_FULL;
        end else begin
          ctl.ins = accept;
          len_nxt = CNT_W'(len_ext + 1'b1);
        end
      end
      FN_ERASE: begin
        if (pos_ext >= len_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.era = accept;
          len_nxt = CNT_W'(len_ext - 1'b1);
        end
      end
      FN_REPLACE: begin
        if (pos_ext >= len_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.rep = accept;
        end
      end
      FN_READ: begin
        if (pos_ext >= len_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.rd = 1'b1;
        end
      end
      FN_RESIZE: begin
        if (target_ext > CAP_C) begin
          status = ST_FULL;
        end else begin
          ctl.fil = accept;
          len_nxt = CNT_W'(target_ext);
        end
      end
      FN_CLEAR: begin
        len_nxt = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_data[g+1];
    end

    ilst_cell #(
      .INDEX      (g),
      .CMP_W      (CMP_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_ext),
      .len        (len_ext),
      .target     (target_ext),
      .word       (word),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[g]),
      .read_tap   (cell_tap[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  assign rd_ext  = EXT_W'(rd_word);
  assign len_out = CMP_W'(len_nxt);

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status;
      out_read_value_r <= rd_ext[31:0];
      out_length_r     <= len_out[6:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_length     = out_length_r;

endmodule

`default_nettype wire

/* rtl/ilst_checker.sv */
// ----------------------------------------------------------------------------
// Indexed list store port checker
// Watches the ports of the core for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_status,
  input wire [31:0] out_read_value,
  input wire [6:0]  out_length
);
  import ilst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_read_value)
      && $stable(out_length))
    else $error("Stalled result item changed.");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted item gave no result item.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled without a waiting result item.");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != 32'd0) |-> (out_status == ST_OK))
    else $error("Read word returned with a failing status.");

endmodule

bind indexed_list_store_core ilst_checker u_ilst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_value (out_read_value),
  .out_length     (out_length)
);

`default_nettype wire
